### src/scaled_color_keyed_blit_defines.svh
// Assertion macros shared by the blit RTL.
// The sampling clock is aclk. SCB_ASSERT holds its check off while aresetn is low;
// SCB_ASSERT_ALWAYS checks during reset as well.
`ifndef SCALED_COLOR_KEYED_BLIT_DEFINES_SVH
`define SCALED_COLOR_KEYED_BLIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("blit assertion failed");
`define SCB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("blit assertion failed");
`else
`define SCB_ASSERT(lbl, prop)
`define SCB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### src/scb_pkg.sv
package scb_pkg;

    // Largest usable rectangle dimension; larger settings are clamped.
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DEST_START = 3'd0,
        CFG_SRC_BASE   = 3'd1,
        CFG_DEST_PITCH = 3'd2,
        CFG_SRC_PITCH  = 3'd3,
        CFG_OUT_WIDTH  = 3'd4,
        CFG_OUT_HEIGHT = 3'd5,
        CFG_STEP       = 3'd6,
        CFG_KEY_COLOUR = 3'd7
    } cfg_index_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [31:0]        dest_start_address;
        logic [31:0]        src_base_address;
        logic [12:0]        dest_pitch;
        logic [12:0]        src_pitch;
        logic [12:0]        out_width;
        logic [12:0]        out_height;
        logic [31:0]        step;
        logic signed [15:0] key_colour;
    } cfg_t;

    // Address walker answer for the request being processed.
    typedef struct packed {
        logic        valid;
        logic [31:0] dest_address;
        logic [31:0] next_src_address;
        logic        last;
    } walk_t;

endpackage

### src/scb_cfg_regs.sv
module scb_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,
    output scb_pkg::cfg_t cfg
);
    import scb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register write.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEST_START: cfg_next.dest_start_address = cfg_wdata;
                CFG_SRC_BASE:   cfg_next.src_base_address   = cfg_wdata;
                CFG_DEST_PITCH: cfg_next.dest_pitch         = cfg_wdata[12:0];
                CFG_SRC_PITCH:  cfg_next.src_pitch          = cfg_wdata[12:0];
                CFG_OUT_WIDTH:  cfg_next.out_width          = cfg_wdata[12:0];
                CFG_OUT_HEIGHT: cfg_next.out_height         = cfg_wdata[12:0];
                CFG_STEP:       cfg_next.step               = cfg_wdata;
                CFG_KEY_COLOUR: cfg_next.key_colour         = cfg_wdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_start_address <= 32'd0;
            cfg_reg.src_base_address   <= 32'd0;
            cfg_reg.dest_pitch         <= 13'd1;
            cfg_reg.src_pitch          <= 13'd1;
            cfg_reg.out_width          <= 13'd0;
            cfg_reg.out_height         <= 13'd0;
            cfg_reg.step               <= 32'h0001_0000;
            cfg_reg.key_colour         <= 16'sd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/scb_walker.sv
`include "scaled_color_keyed_blit_defines.svh"

module scb_walker (
    input  logic          aclk,
    input  logic          aresetn,
    input  scb_pkg::cfg_t cfg,
    input  logic          fire,
    output scb_pkg::walk_t walk
);
    import scb_pkg::*;

    logic [31:0] col_acc_reg,  col_acc_next;
    logic [15:0] row_frac_reg, row_frac_next;
    logic [31:0] src_row_reg,  src_row_next;
    logic [31:0] dest_row_reg, dest_row_next;
    logic [12:0] col_idx_reg,  col_idx_next;
    logic [12:0] row_idx_reg,  row_idx_next;

    logic [12:0] width_lim;
    logic [12:0] height_lim;
    logic        empty;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic        row_end;
    logic        rect_end;
    logic [31:0] row_sum;
    logic [29:0] src_row_step;
    logic        walk_at_origin;

    // Clamp the rectangle size to the supported maximum.
    assign width_lim  = (cfg.out_width  > MAX_DIM) ? MAX_DIM : cfg.out_width;
    assign height_lim = (cfg.out_height > MAX_DIM) ? MAX_DIM : cfg.out_height;
    assign empty      = (width_lim == 13'd0) || (height_lim == 13'd0);

    // Row and rectangle end detection.
    assign col_inc  = col_idx_reg + 13'd1;
    assign row_inc  = row_idx_reg + 13'd1;
    assign row_end  = (col_inc >= width_lim);
    assign rect_end = row_end && (row_inc >= height_lim);

    // Vertical advance: whole units of the row sum move on by source pitches.
    assign row_sum      = {16'd0, row_frac_reg} + cfg.step;
    assign src_row_step = {14'd0, row_sum[31:16]} * {16'd0, cfg.src_pitch, 1'b0};

    always_comb begin
        col_acc_next  = col_acc_reg;
        row_frac_next = row_frac_reg;
        src_row_next  = src_row_reg;
        dest_row_next = dest_row_reg;
        col_idx_next  = col_idx_reg;
        row_idx_next  = row_idx_reg;
        if (rect_end) begin
            col_acc_next  = 32'd0;
            row_frac_next = 16'd0;
            src_row_next  = 32'd0;
            dest_row_next = 32'd0;
            col_idx_next  = 13'd0;
            row_idx_next  = 13'd0;
        end else if (row_end) begin
            col_acc_next  = 32'd0;
            row_frac_next = row_sum[15:0];
            src_row_next  = src_row_reg + {2'd0, src_row_step};
            dest_row_next = dest_row_reg + {18'd0, cfg.dest_pitch, 1'b0};
            col_idx_next  = 13'd0;
            row_idx_next  = row_inc;
        end else begin
            col_acc_next  = col_acc_reg + cfg.step;
            col_idx_next  = col_inc;
        end
    end

    // Addresses for the current request.
    always_comb begin
        walk.valid        = !empty;
        walk.dest_address = cfg.dest_start_address + dest_row_reg
                          + {18'd0, col_idx_reg, 1'b0};
        walk.next_src_address = cfg.src_base_address + src_row_next
                              + {15'd0, col_acc_next[31:16], 1'b0};
        walk.last         = rect_end;
    end

    // Walk state advances only on a request that produces a result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_acc_reg  <= 32'd0;
            row_frac_reg <= 16'd0;
            src_row_reg  <= 32'd0;
            dest_row_reg <= 32'd0;
            col_idx_reg  <= 13'd0;
            row_idx_reg  <= 13'd0;
        end else if (fire && !empty) begin
            col_acc_reg  <= col_acc_next;
            row_frac_reg <= row_frac_next;
            src_row_reg  <= src_row_next;
            dest_row_reg <= dest_row_next;
            col_idx_reg  <= col_idx_next;
            row_idx_reg  <= row_idx_next;
        end
    end

    // The walk sits at the first pixel of the rectangle.
    assign walk_at_origin = (col_idx_reg == 13'd0) && (row_idx_reg == 13'd0)
                         && (col_acc_reg == 32'd0) && (src_row_reg == 32'd0);

    `SCB_ASSERT(a_col_in_range, col_idx_reg < MAX_DIM)
    `SCB_ASSERT(a_row_in_range, row_idx_reg < MAX_DIM)
    `SCB_ASSERT(a_rect_end_clears, fire && !empty && rect_end |=> walk_at_origin)
    `SCB_ASSERT(a_empty_holds, fire && empty |=> $stable({col_idx_reg, row_idx_reg, col_acc_reg}))

endmodule

### src/scaled_color_keyed_blit.sv
// An accepted request waits in the input register and moves to the result register on m_*
// once that stage is free or is being drained by m_tready.
// Throughput: one request per cycle unless m_tready back-pressure stalls the result stage.
// A request made while width or height is zero is consumed and gives no result.
// Reset: aresetn is synchronous and active low; it empties both pipeline stages,
// returns the walk to the first pixel and loads the register defaults.
`include "scaled_color_keyed_blit_defines.svh"

module scaled_color_keyed_blit (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Source pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] src_pixel
    // Destination write stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [31:0] dest_address, [47:32] pixel_value,
                                   // [79:48] next_src_address
    output logic [0:0]  m_tuser,   // [0] write_enable
    output logic        m_tlast    // last
);
    import scb_pkg::*;

    cfg_t  cfg;
    walk_t walk;

    logic               in_valid_reg, in_valid_next;
    logic signed [15:0] in_pixel_reg;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_dest_reg;
    logic [31:0]        out_nsrc_reg;
    logic [15:0]        out_pixel_reg;
    logic               out_we_reg;
    logic               out_last_reg;

    logic advance;
    logic fire;
    logic s_accept;
    logic nsrc_at_base;

    scb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    scb_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .walk    (walk)
    );

    // Stage handshakes: the input stage moves on whenever the result stage is free.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = walk.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_pixel_reg <= s_tdata;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_dest_reg  <= walk.dest_address;
            out_nsrc_reg  <= walk.next_src_address;
            out_pixel_reg <= in_pixel_reg;
            out_we_reg    <= (in_pixel_reg != cfg.key_colour);
            out_last_reg  <= walk.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_nsrc_reg, out_pixel_reg, out_dest_reg};
    assign m_tuser  = out_we_reg;
    assign m_tlast  = out_last_reg;

    // The held next source address points back at the source base.
    assign nsrc_at_base = (out_nsrc_reg == cfg.src_base_address);

    `SCB_ASSERT_ALWAYS(a_ready_only_blocked_by_stage, !s_tready |-> in_valid_reg && out_valid_reg)
    `SCB_ASSERT(a_last_restarts_source, out_valid_reg && out_last_reg |-> nsrc_at_base)
    `SCB_ASSERT(a_result_needs_fire, $rose(out_valid_reg) |-> $past(fire))

endmodule
